@@ design/mlfd_pkg.sv @@
// shared types and constants for the marker/length frame deframer
`default_nettype none

package mlfd_pkg;

    // receive phase of the deframer
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    // frame kind codes as seen on frame_kind
    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_U = 2'd1;
    localparam logic [1:0] KIND_A = 2'd2;

    // input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_BEGIN_MARK    = 3'd0;
    localparam logic [2:0] CFG_I_TYPE_MARK   = 3'd1;
    localparam logic [2:0] CFG_U_TYPE_MARK   = 3'd2;
    localparam logic [2:0] CFG_A_TYPE_MARK   = 3'd3;
    localparam logic [2:0] CFG_I_EXTRA_BYTES = 3'd4;
    localparam logic [2:0] CFG_U_BODY_BYTES  = 3'd5;

    // length field of type I frames keeps its low 15 bits
    localparam int LEN_FIELD_BITS = 15;
    localparam logic [LEN_FIELD_BITS-1:0] LEN_FIELD_MASK = 15'h7fff;

endpackage

`default_nettype wire

@@ design/marker_length_frame_deframer_top.sv @@
// Marker/length frame deframer: hunts a begin mark, decodes type I/U/A frames.
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; in_stall rises only while the result register is full
// and stalled and the held item would make a result.
// Reset: async active low; returns to hunting, config registers take their reset values.
`default_nettype none

module marker_length_frame_deframer_top
    import mlfd_pkg::*;
#(
    parameter int REMAINING_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic [7:0] rx_byte,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      frame_byte,
    output logic [1:0]      frame_kind,
    output logic            frame_last,
    output logic            frame_abort
);

    localparam logic [REMAINING_BITS-1:0] REM_ONE = REMAINING_BITS'(1);

    // configuration registers
    logic [7:0] begin_mark_reg;
    logic [7:0] i_type_mark_reg;
    logic [7:0] u_type_mark_reg;
    logic [7:0] a_type_mark_reg;
    logic [7:0] i_extra_bytes_reg;
    logic [7:0] u_body_bytes_reg;

    // input register
    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_byte_reg;

    // deframer state
    phase_t                    phase_reg, phase_next;
    logic [1:0]                kind_reg, kind_next;
    logic [7:0]                len_lo_reg, len_lo_next;
    logic [REMAINING_BITS-1:0] remain_reg, remain_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] frame_byte_reg;
    logic [1:0] frame_kind_reg;
    logic       frame_last_reg;
    logic       frame_abort_reg;

    // result of the held item
    logic       res_valid;
    logic [7:0] res_byte;
    logic [1:0] res_kind;
    logic       res_last;
    logic       res_abort;

    logic                      in_accept;
    logic                      out_free;
    logic                      s1_adv;
    logic                      is_i_mark;
    logic                      is_u_mark;
    logic                      is_a_mark;
    logic [LEN_FIELD_BITS-1:0] len_field;
    logic [REMAINING_BITS-1:0] u_count;
    logic [REMAINING_BITS-1:0] i_count;
    logic [REMAINING_BITS-1:0] body_dec;

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && (!res_valid || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // type mark match and body counts
    assign is_i_mark = (s1_byte_reg == i_type_mark_reg);
    assign is_u_mark = (s1_byte_reg == u_type_mark_reg);
    assign is_a_mark = (s1_byte_reg == a_type_mark_reg);
    assign len_field = {s1_byte_reg[6:0], len_lo_reg} & LEN_FIELD_MASK;
    assign u_count   = REMAINING_BITS'(u_body_bytes_reg);
    assign i_count   = REMAINING_BITS'(len_field) + REMAINING_BITS'(i_extra_bytes_reg);
    assign body_dec  = remain_reg - REM_ONE;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_mark_reg    <= 8'd0;
            i_type_mark_reg   <= 8'd1;
            u_type_mark_reg   <= 8'd2;
            a_type_mark_reg   <= 8'd3;
            i_extra_bytes_reg <= 8'd3;
            u_body_bytes_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BEGIN_MARK:    begin_mark_reg    <= cfg_data;
                CFG_I_TYPE_MARK:   i_type_mark_reg   <= cfg_data;
                CFG_U_TYPE_MARK:   u_type_mark_reg   <= cfg_data;
                CFG_A_TYPE_MARK:   a_type_mark_reg   <= cfg_data;
                CFG_I_EXTRA_BYTES: i_extra_bytes_reg <= cfg_data;
                CFG_U_BODY_BYTES:  u_body_bytes_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= operation;
            s1_byte_reg <= rx_byte;
        end
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        if (s1_op_reg == OP_TIMEOUT)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (s1_byte_reg == begin_mark_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    priority if (is_i_mark)
                    begin
                        kind_next  = KIND_I;
                        phase_next = PH_LEN_LO;
                    end
                    else if (is_u_mark)
                    begin
                        kind_next   = KIND_U;
                        remain_next = u_count;
                        phase_next  = (u_count == '0) ? PH_HUNT : PH_BODY;
                    end
                    else if (is_a_mark)
                    begin
                        kind_next  = KIND_A;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN_LO:
                begin
                    len_lo_next = s1_byte_reg;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    remain_next = i_count;
                    phase_next  = (i_count == '0) ? PH_HUNT : PH_BODY;
                end
                PH_BODY:
                begin
                    remain_next = body_dec;
                    if (body_dec == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    // unused phase codes behave as hunting
                    if (s1_byte_reg == begin_mark_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // result of the held item
    always_comb
    begin
        res_valid = 1'b0;
        res_byte  = s1_byte_reg;
        res_kind  = kind_reg;
        res_last  = 1'b0;
        res_abort = 1'b0;
        if (s1_op_reg == OP_TIMEOUT)
        begin
            if (phase_reg == PH_LEN_LO || phase_reg == PH_LEN_HI || phase_reg == PH_BODY)
            begin
                res_valid = 1'b1;
                res_byte  = 8'd0;
                res_abort = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    priority if (is_i_mark)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_I;
                    end
                    else if (is_u_mark)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_U;
                        res_last  = (u_count == '0);
                    end
                    else if (is_a_mark)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_A;
                        res_last  = 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b0;
                    end
                end
                PH_LEN_LO:
                begin
                    res_valid = 1'b1;
                end
                PH_LEN_HI:
                begin
                    res_valid = 1'b1;
                    res_last  = (i_count == '0);
                end
                PH_BODY:
                begin
                    res_valid = 1'b1;
                    res_last  = (body_dec == '0);
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // deframer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            kind_reg   <= KIND_I;
            len_lo_reg <= 8'd0;
            remain_reg <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_valid)
        begin
            frame_byte_reg  <= res_byte;
            frame_kind_reg  <= res_kind;
            frame_last_reg  <= res_last;
            frame_abort_reg <= res_abort;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign frame_kind  = frame_kind_reg;
    assign frame_last  = frame_last_reg;
    assign frame_abort = frame_abort_reg;

endmodule

`default_nettype wire

@@ design/mlfd_checker.sv @@
// port-level checks for the marker/length frame deframer, bound to the top level
`default_nettype none

module mlfd_checker
    import mlfd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] frame_byte,
    input wire logic [1:0] frame_kind,
    input wire logic       frame_last,
    input wire logic       frame_abort
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(frame_kind)
            && $stable(frame_last) && $stable(frame_abort))
        else $error("stalled result changed");

    // an abort carries a zero byte and no last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_abort |-> frame_byte == 8'd0 && !frame_last)
        else $error("abort item with byte or last flag");

    // only the three kind codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_kind == KIND_I || frame_kind == KIND_U || frame_kind == KIND_A)
        else $error("bad frame kind");

    // a type A frame is a single complete item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == KIND_A |-> frame_last && !frame_abort)
        else $error("type A item not final");

endmodule

bind marker_length_frame_deframer_top mlfd_checker u_mlfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .frame_kind  (frame_kind),
    .frame_last  (frame_last),
    .frame_abort (frame_abort)
);

`default_nettype wire
